[hdl/assert_macros.svh]
// Assertion macros for the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clk edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/qesd_pkg.sv]
// Types, constants and step tables for the quadrature step decoder.
`default_nettype none
package qesd_pkg;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    typedef struct packed {
        logic [2:0] row;
        dir_t       dir;
    } step_t;

    // Entry: [5:4] emission, [2:0] next row.
    localparam logic [5:0] EMIT_CW  = 6'h10;
    localparam logic [5:0] EMIT_CCW = 6'h20;
    localparam logic [5:0] DIR_MASK = 6'h30;
    localparam logic [2:0] HALF_LAST_ROW = 3'd5;
    localparam logic [2:0] FULL_LAST_ROW = 3'd6;

    localparam logic signed [7:0] ACC_MAX = 8'sd127;
    localparam logic signed [7:0] ACC_MIN = -8'sd127;

    localparam logic [5:0] HALF_TAB [0:5][0:3] = '{
        '{6'h03,            6'h02, 6'h01, 6'h00},
        '{6'h03 | EMIT_CCW, 6'h00, 6'h01, 6'h00},
        '{6'h03 | EMIT_CW,  6'h02, 6'h00, 6'h00},
        '{6'h03,            6'h05, 6'h04, 6'h00},
        '{6'h03,            6'h03, 6'h04, 6'h00 | EMIT_CW},
        '{6'h03,            6'h05, 6'h03, 6'h00 | EMIT_CCW}
    };

    localparam logic [5:0] FULL_TAB [0:6][0:3] = '{
        '{6'h00, 6'h02, 6'h04, 6'h00},
        '{6'h03, 6'h00, 6'h01, 6'h00 | EMIT_CW},
        '{6'h03, 6'h02, 6'h00, 6'h00},
        '{6'h03, 6'h02, 6'h01, 6'h00 | EMIT_CW},
        '{6'h06, 6'h00, 6'h04, 6'h00},
        '{6'h06, 6'h05, 6'h00, 6'h00 | EMIT_CCW},
        '{6'h06, 6'h05, 6'h04, 6'h00 | EMIT_CCW}
    };

    // Rows past the table fall back to start.
    function automatic logic [5:0] half_entry(input logic [2:0] row, input logic [1:0] code);
        logic [2:0] r;
        r = (row > HALF_LAST_ROW) ? 3'd0 : row;
        return HALF_TAB[r][code];
    endfunction

    function automatic logic [5:0] full_entry(input logic [2:0] row, input logic [1:0] code);
        logic [2:0] r;
        r = (row > FULL_LAST_ROW) ? 3'd0 : row;
        return FULL_TAB[r][code];
    endfunction

endpackage
`default_nettype wire

[hdl/qesd_sample_if.sv]
// Input channel: one pin sample per beat.
`default_nettype none
interface qesd_sample_if;
    logic valid;
    logic ready;
    logic req_type;
    logic pin_a;
    logic pin_b;

    modport source (output valid, output req_type, output pin_a, output pin_b, input ready);
    modport sink   (input valid, input req_type, input pin_a, input pin_b, output ready);
endinterface
`default_nettype wire

[hdl/qesd_result_if.sv]
// Output channel: one decode result per beat.
`default_nettype none
interface qesd_result_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] turn_count;
    logic [1:0]        step_dir;

    modport source (output valid, output turn_count, output step_dir, input ready);
    modport sink   (input valid, input turn_count, input step_dir, output ready);
endinterface
`default_nettype wire

[hdl/quadrature_encoder_step_decoder.sv]
// Top level: quadrature encoder step decoder with saturating turn count.
// The result is registered: a result beat follows in the cycle after its sample beat is accepted.
// Throughput: one sample per cycle unless the result beat stalls; the table row and count update at accept,
// and the result register frees in the same cycle its beat is taken.
// Reset: step_mode half-step, table row start, count zero, result empty.
`default_nettype none
`include "assert_macros.svh"
module quadrature_encoder_step_decoder
    import qesd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step_mode_we,
    input  wire logic    step_mode_wdata,
    qesd_sample_if.sink  sample,
    qesd_result_if.source result
);

    logic              step_mode_reg;
    logic [2:0]        table_state_reg;
    logic signed [7:0] turn_accum_reg;
    logic signed [7:0] turn_accum_next;
    logic signed [7:0] stepped;
    logic signed [7:0] count_next;

    logic              out_valid_reg;
    logic signed [7:0] turn_count_reg;
    logic [1:0]        step_dir_reg;

    logic  accept;
    step_t step;

    // Result register drains or is empty: take a new sample beat.
    assign sample.ready = !out_valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;

    qesd_step_table u_table (
        .full_mode (step_mode_reg),
        .row       (table_state_reg),
        .code      ({sample.pin_a, sample.pin_b}),
        .step      (step)
    );

    // Saturating step; step_dir still reports an emission held at the limit.
    always_comb
    begin
        stepped = turn_accum_reg;
        case (step.dir)
            DIR_CW:
            begin
                if (turn_accum_reg < ACC_MAX)
                    stepped = turn_accum_reg + 8'sd1;
            end
            DIR_CCW:
            begin
                if (turn_accum_reg > ACC_MIN)
                    stepped = turn_accum_reg - 8'sd1;
            end
            default: stepped = turn_accum_reg;
        endcase

        // Read request returns the updated count and clears it.
        if (sample.req_type)
        begin
            count_next      = stepped;
            turn_accum_next = 8'sd0;
        end
        else
        begin
            count_next      = 8'sd0;
            turn_accum_next = stepped;
        end
    end

    // Config write must only be issued while idle; the block itself does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_mode_reg <= 1'b0;
        else if (step_mode_we)
            step_mode_reg <= step_mode_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_state_reg <= 3'd0;
            turn_accum_reg  <= 8'sd0;
        end
        else if (accept)
        begin
            table_state_reg <= step.row;
            turn_accum_reg  <= turn_accum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            turn_count_reg <= count_next;
            step_dir_reg   <= step.dir;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.turn_count = turn_count_reg;
    assign result.step_dir   = step_dir_reg;

    `ASSERT_CLK_ALWAYS(a_accum_in_range, turn_accum_reg != -8'sd128, "turn accumulator left -127..127")
    `ASSERT_CLK_ALWAYS(a_row_in_table, table_state_reg != 3'd7, "table row outside both tables")
    `ASSERT_CLK(a_read_clears, accept && sample.req_type |=> turn_accum_reg == 8'sd0, "read did not clear count")
    `ASSERT_CLK(a_accept_fills, accept |=> out_valid_reg, "accepted sample beat produced no result")

endmodule
`default_nettype wire

[hdl/qesd_step_table.sv]
// Table lookup: stored row and pin code to next row and emission.
`default_nettype none
module qesd_step_table
    import qesd_pkg::*;
(
    input  wire logic       full_mode,
    input  wire logic [2:0] row,
    input  wire logic [1:0] code,
    output step_t           step
);

    logic [5:0] entry;

    always_comb
    begin
        entry = full_mode ? full_entry(row, code) : half_entry(row, code);
        step.row = entry[2:0];
        case (entry & DIR_MASK)
            EMIT_CW:  step.dir = DIR_CW;
            EMIT_CCW: step.dir = DIR_CCW;
            default:  step.dir = DIR_NONE;
        endcase
    end

endmodule
`default_nettype wire
